>>> sv/pwpc_pkg.sv
// ----------------------------------------------------------------------------
// Periodic window point counter package
// Shared widths, operation codes and register indexes for the counter and its
// request and result interfaces.
// ----------------------------------------------------------------------------
package pwpc_pkg;

    localparam int COORD_BITS   = 24;
    localparam int RADIUS_BITS  = 48;
    localparam int OP_BITS      = 2;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = RADIUS_BITS;

    localparam int WIN_BITS     = 13;
    localparam int SUM_BITS     = 32;
    localparam int SQ_SUM_BITS  = 44;
    localparam int SAMPLE_BITS  = 20;
    localparam int STORED_BITS  = 13;

    localparam logic [COORD_BITS-1:0] BOX_LENGTH_RESET = 24'd8388608;

    typedef logic [OP_BITS-1:0]    t_op;
    typedef logic [COORD_BITS-1:0] t_coord;

    localparam t_op OP_LOAD   = 2'd0;
    localparam t_op OP_SAMPLE = 2'd1;
    localparam t_op OP_READ   = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_LENGTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_SQ  = 1'd1;

endpackage

>>> sv/pwpc_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one operation and a pair of coordinates.
// ----------------------------------------------------------------------------
interface pwpc_in_if
    import pwpc_pkg::*;
();
    logic   valid;
    logic   ready;
    t_op    op;
    t_coord x_coord;
    t_coord y_coord;

    modport source (output valid, output op, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input op, input x_coord, input y_coord, output ready);
endinterface

>>> sv/pwpc_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the window count and the running totals.
// ----------------------------------------------------------------------------
interface pwpc_out_if
    import pwpc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [WIN_BITS-1:0]    window_count;
    logic [SUM_BITS-1:0]    count_sum;
    logic [SQ_SUM_BITS-1:0] count_square_sum;
    logic [SAMPLE_BITS-1:0] samples_taken;
    logic [STORED_BITS-1:0] points_stored;
    logic                   load_overflow;

    modport source (output valid, output window_count, output count_sum,
                    output count_square_sum, output samples_taken,
                    output points_stored, output load_overflow, input ready);
    modport sink   (input valid, input window_count, input count_sum,
                    input count_square_sum, input samples_taken,
                    input points_stored, input load_overflow, output ready);
endinterface

>>> sv/periodic_window_point_counter.sv
// ----------------------------------------------------------------------------
// Periodic window point counter
// Stores 2D points in a periodic box and counts those inside sampled windows.
// ----------------------------------------------------------------------------
// A load request stores one point, a sample request counts the stored points
// whose minimum-image squared distance to the given centre is below the
// radius squared and folds the count into running totals, and a read request
// returns the totals and clears them. Every request gives exactly one result.
// The block takes one request at a time: loads, reads and unused codes go
// straight to the finish state, while a sample scans all N stored points and
// drains the distance pipeline first (it skips both with an empty store),
// because the single read port of the point memory feeds the distance
// pipeline one point per cycle. A finished result waits in the output
// register while the next request is accepted.
// The point memory needs no clearing after reset; only loaded entries are counted.
// ----------------------------------------------------------------------------
module periodic_window_point_counter
    import pwpc_pkg::*;
#(
    parameter int MAX_POINTS = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    pwpc_in_if.sink                  i_req,
    pwpc_out_if.source               o_res
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_POINTS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_SQUARE = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    // Folds an axis distance onto its minimum image in the periodic box.
    function automatic t_coord fold_distance(input t_coord d, input t_coord len);
        t_coord r;
        if ({d, 1'b0} > {1'b0, len}) begin
            r = (len > d) ? (len - d) : (d - len);
        end else begin
            r = d;
        end
        return r;
    endfunction

    logic [2:0]             r_state;
    t_coord                 r_box_len;
    logic [RADIUS_BITS-1:0] r_radius_sq;

    t_op                    r_op;
    t_coord                 r_x;
    t_coord                 r_y;

    logic [CNT_W-1:0]       r_total;
    logic [CNT_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_win;
    logic [2*CNT_W-1:0]     r_win_sq;
    logic [SUM_BITS-1:0]    r_cnt_sum;
    logic [SQ_SUM_BITS-1:0] r_sq_sum;
    logic [SAMPLE_BITS-1:0] r_samples;

    logic [2*COORD_BITS-1:0] r_mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0] r_rd;

    logic                   r_v1, r_v2, r_v3, r_v4;
    t_coord                 r_ax, r_ay;
    t_coord                 r_fx, r_fy;
    logic [SQ_W-1:0]        r_dx2, r_dy2;

    logic                   r_out_v;
    logic [WIN_BITS-1:0]    r_o_win;
    logic [SUM_BITS-1:0]    r_o_sum;
    logic [SQ_SUM_BITS-1:0] r_o_sq;
    logic [SAMPLE_BITS-1:0] r_o_samples;
    logic [STORED_BITS-1:0] r_o_stored;
    logic                   r_o_ovf;

    logic                   w_accept;
    logic                   w_commit;
    logic                   w_full;
    logic                   w_mem_we;
    logic                   w_issue;
    t_coord                 w_mx, w_my;
    logic [SQ_W:0]          w_dist_sq;

    logic [SUM_BITS:0]      w_cnt_add;
    logic [SQ_SUM_BITS:0]   w_sq_add;
    logic [SUM_BITS-1:0]    n_cnt_sum;
    logic [SQ_SUM_BITS-1:0] n_sq_sum;
    logic [SAMPLE_BITS-1:0] n_samples;
    logic [CNT_W-1:0]       n_total;
    logic                   n_ovf;
    logic [SUM_BITS-1:0]    n_o_sum;
    logic [SQ_SUM_BITS-1:0] n_o_sq;
    logic [SAMPLE_BITS-1:0] n_o_samples;
    logic [CNT_W+WIN_BITS-1:0]    w_win_ext;
    logic [CNT_W+STORED_BITS-1:0] w_total_ext;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_commit    = (r_state == S_FIN) && (!r_out_v || o_res.ready);
    assign w_full      = (r_total == FULL_COUNT);
    assign w_mem_we    = w_commit && (r_op == OP_LOAD) && !w_full;
    assign w_issue     = (r_state == S_SCAN);
    assign w_mx        = r_rd[2*COORD_BITS-1:COORD_BITS];
    assign w_my        = r_rd[COORD_BITS-1:0];
    assign w_dist_sq   = {1'b0, r_dx2} + {1'b0, r_dy2};

    // Totals saturate: the sum never exceeds its ceiling, so a clamp of the
    // widened sum gives the same answer as the guarded add.
    assign w_cnt_add = {1'b0, r_cnt_sum} + (SUM_BITS + 1)'(r_win);
    assign w_sq_add  = {1'b0, r_sq_sum} + (SQ_SUM_BITS + 1)'(r_win_sq);

    always_comb begin
        n_cnt_sum   = r_cnt_sum;
        n_sq_sum    = r_sq_sum;
        n_samples   = r_samples;
        n_total     = r_total;
        n_ovf       = 1'b0;
        n_o_sum     = r_cnt_sum;
        n_o_sq      = r_sq_sum;
        n_o_samples = r_samples;
        unique case (r_op)
            OP_LOAD: begin
                if (w_full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_total = r_total + 1'b1;
                end
            end
            OP_SAMPLE: begin
                n_cnt_sum = w_cnt_add[SUM_BITS] ? '1 : w_cnt_add[SUM_BITS-1:0];
                n_sq_sum  = w_sq_add[SQ_SUM_BITS] ? '1 : w_sq_add[SQ_SUM_BITS-1:0];
                if (w_cnt_add[SUM_BITS-1:0] == '1) begin
                    n_cnt_sum = '1;
                end
                if (w_sq_add[SQ_SUM_BITS-1:0] == '1) begin
                    n_sq_sum = '1;
                end
                n_samples   = (r_samples == '1) ? r_samples : r_samples + 1'b1;
                n_o_sum     = n_cnt_sum;
                n_o_sq      = n_sq_sum;
                n_o_samples = n_samples;
            end
            OP_READ: begin
                n_cnt_sum = '0;
                n_sq_sum  = '0;
                n_samples = '0;
            end
            default: begin
            end
        endcase
    end

    assign w_win_ext   = {{WIN_BITS{1'b0}}, ((r_op == OP_SAMPLE) ? r_win : '0)};
    assign w_total_ext = {{STORED_BITS{1'b0}}, n_total};

    // Point memory: one write port for loads, one registered read port for scans.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_total[AW-1:0]] <= {r_x, r_y};
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    // Distance pipeline: fetch, absolute difference, periodic fold, squares.
    always_ff @(posedge i_clk) begin
        r_ax     <= (w_mx > r_x) ? (w_mx - r_x) : (r_x - w_mx);
        r_ay     <= (w_my > r_y) ? (w_my - r_y) : (r_y - w_my);
        r_fx     <= fold_distance(r_ax, r_box_len);
        r_fy     <= fold_distance(r_ay, r_box_len);
        r_dx2    <= r_fx * r_fx;
        r_dy2    <= r_fy * r_fy;
        r_win_sq <= r_win * r_win;
        if (w_accept) begin
            r_op <= i_req.op;
            r_x  <= i_req.x_coord;
            r_y  <= i_req.y_coord;
        end
        if (w_commit) begin
            r_o_win     <= w_win_ext[WIN_BITS-1:0];
            r_o_sum     <= n_o_sum;
            r_o_sq      <= n_o_sq;
            r_o_samples <= n_o_samples;
            r_o_stored  <= w_total_ext[STORED_BITS-1:0];
            r_o_ovf     <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_box_len   <= BOX_LENGTH_RESET;
            r_radius_sq <= '0;
            r_total     <= '0;
            r_idx       <= '0;
            r_win       <= '0;
            r_cnt_sum   <= '0;
            r_sq_sum    <= '0;
            r_samples   <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BOX_LENGTH: r_box_len   <= i_cfg_data[COORD_BITS-1:0];
                    CFG_RADIUS_SQ:  r_radius_sq <= i_cfg_data[RADIUS_BITS-1:0];
                    default: begin
                    end
                endcase
            end

            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (r_v4 && (w_dist_sq < {1'b0, r_radius_sq})) begin
                r_win <= r_win + 1'b1;
            end

            if (w_commit) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_win <= '0;
                        r_idx <= '0;
                        if (i_req.op != OP_SAMPLE) begin
                            r_state <= S_FIN;
                        end else if (r_total == '0) begin
                            r_state <= S_SQUARE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_total) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!(r_v1 || r_v2 || r_v3 || r_v4)) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_commit) begin
                        r_total   <= n_total;
                        r_cnt_sum <= n_cnt_sum;
                        r_sq_sum  <= n_sq_sum;
                        r_samples <= n_samples;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid            = r_out_v;
    assign o_res.window_count     = r_o_win;
    assign o_res.count_sum        = r_o_sum;
    assign o_res.count_square_sum = r_o_sq;
    assign o_res.samples_taken    = r_o_samples;
    assign o_res.points_stored    = r_o_stored;
    assign o_res.load_overflow    = r_o_ovf;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Periodic window point counter testbench
// Drives load, sample, read and unused requests into the counter with random
// idling on both channels. Every accepted request is run through a local
// predictor of the point store and the running totals, and each result is
// compared field by field with the oldest expected report.
// ----------------------------------------------------------------------------
module tb_top;
    import pwpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          POINT_CAPACITY = 4096;
    localparam t_op         OP_UNUSED      = 2'd3;
    localparam int          QUIET_LIMIT    = 30000;
    localparam int          LONG_STALL     = 300;
    localparam logic [63:0] COUNT_SUM_MAX  = 64'hFFFF_FFFF;
    localparam logic [63:0] SQUARE_SUM_MAX = 64'hFFF_FFFF_FFFF;
    localparam logic [63:0] SAMPLES_MAX    = 64'hF_FFFF;

    typedef struct packed {
        t_op    op;
        t_coord x_coord;
        t_coord y_coord;
    } request_t;

    typedef struct packed {
        logic [WIN_BITS-1:0]    window_count;
        logic [SUM_BITS-1:0]    count_sum;
        logic [SQ_SUM_BITS-1:0] count_square_sum;
        logic [SAMPLE_BITS-1:0] samples_taken;
        logic [STORED_BITS-1:0] points_stored;
        logic                   load_overflow;
    } window_report_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    pwpc_in_if  req_if ();
    pwpc_out_if res_if ();

    periodic_window_point_counter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // Predictor state: configuration, point store and running totals.
    t_coord                   box_len_cfg   = BOX_LENGTH_RESET;
    logic [RADIUS_BITS-1:0]   radius_sq_cfg = '0;
    t_coord                   stored_x [POINT_CAPACITY];
    t_coord                   stored_y [POINT_CAPACITY];
    int                       points_held   = 0;
    logic [63:0]              count_total   = '0;
    logic [63:0]              square_total  = '0;
    logic [63:0]              sample_count  = '0;

    request_t       requests_pending [$];
    window_report_t reports_due [$];

    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    int unsigned stall_requests  = 0;
    int unsigned stalls_served   = 0;
    int unsigned stall_left      = 0;
    int unsigned issued          = 0;
    int unsigned accepted        = 0;
    int unsigned results_checked = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned errors          = 0;
    int unsigned ops_seen [4]    = '{0, 0, 0, 0};
    int unsigned loads_dropped   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Known values on every input from time zero.
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        req_if.valid   = 1'b0;
        req_if.op      = OP_LOAD;
        req_if.x_coord = '0;
        req_if.y_coord = '0;
        res_if.ready   = 1'b0;
    end

    function automatic logic [63:0] min_image_gap(input t_coord a, input t_coord b);
        logic [63:0] d;
        logic [63:0] len;
        len = {40'd0, box_len_cfg};
        d   = (a > b) ? 64'(a - b) : 64'(b - a);
        if ((d << 1) > len)
            d = (len > d) ? len - d : d - len;
        return d;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] max);
        if (a >= max || b >= max - a)
            return max;
        return a + b;
    endfunction

    // Applies one request to the predictor and returns the report it yields.
    function automatic window_report_t compute_report(input request_t rq);
        window_report_t rep;
        logic [63:0]    hits;
        logic [63:0]    gap_x;
        logic [63:0]    gap_y;
        int             i;
        rep  = '0;
        hits = '0;
        case (rq.op)
            OP_LOAD: begin
                if (points_held < POINT_CAPACITY) begin
                    stored_x[points_held] = rq.x_coord;
                    stored_y[points_held] = rq.y_coord;
                    points_held++;
                end else begin
                    rep.load_overflow = 1'b1;
                end
            end
            OP_SAMPLE: begin
                for (i = 0; i < points_held; i++) begin
                    gap_x = min_image_gap(stored_x[i], rq.x_coord);
                    gap_y = min_image_gap(stored_y[i], rq.y_coord);
                    if (gap_x * gap_x + gap_y * gap_y < {16'd0, radius_sq_cfg})
                        hits++;
                end
                count_total  = sat_add(count_total, hits, COUNT_SUM_MAX);
                square_total = sat_add(square_total, hits * hits, SQUARE_SUM_MAX);
                sample_count = sat_add(sample_count, 64'd1, SAMPLES_MAX);
            end
            default: begin
            end
        endcase
        rep.window_count     = hits[WIN_BITS-1:0];
        rep.count_sum        = count_total[SUM_BITS-1:0];
        rep.count_square_sum = square_total[SQ_SUM_BITS-1:0];
        rep.samples_taken    = sample_count[SAMPLE_BITS-1:0];
        rep.points_stored    = STORED_BITS'(points_held);
        // A read reports the totals as they stood, then clears them.
        if (rq.op == OP_READ) begin
            count_total  = '0;
            square_total = '0;
            sample_count = '0;
        end
        return rep;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        request_t nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = requests_pending.pop_front();
                req_if.valid   <= 1'b1;
                req_if.op      <= nxt.op;
                req_if.x_coord <= nxt.x_coord;
                req_if.y_coord <= nxt.y_coord;
                issued++;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Request monitor: predicts the report for every accepted request.
    always @(posedge i_clk) begin
        request_t       rq;
        window_report_t rep;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            rq.op      = req_if.op;
            rq.x_coord = req_if.x_coord;
            rq.y_coord = req_if.y_coord;
            rep = compute_report(rq);
            reports_due.insert(reports_due.size(), rep);
            ops_seen[rq.op]++;
            if (rep.load_overflow)
                loads_dropped++;
            accepted++;
        end
    end

    // Result ready: random idling, plus long hold-offs on demand.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (stalls_served != stall_requests) begin
            res_if.ready  <= 1'b0;
            stall_left    <= LONG_STALL;
            stalls_served <= stalls_served + 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        window_report_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (reports_due.size() == 0) begin
                $display("%0t: result with nothing expected, window_count %0d", $time,
                         res_if.window_count);
                errors++;
            end else begin
                want = reports_due.pop_front();
                check_field("window_count", 64'(want.window_count),
                            64'(res_if.window_count));
                check_field("count_sum", 64'(want.count_sum), 64'(res_if.count_sum));
                check_field("count_square_sum", 64'(want.count_square_sum),
                            64'(res_if.count_square_sum));
                check_field("samples_taken", 64'(want.samples_taken),
                            64'(res_if.samples_taken));
                check_field("points_stored", 64'(want.points_stored),
                            64'(res_if.points_stored));
                check_field("load_overflow", 64'(want.load_overflow),
                            64'(res_if.load_overflow));
                results_checked++;
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (requests_pending.size() != 0 || issued != accepted || reports_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        if (idx == CFG_BOX_LENGTH)
            box_len_cfg = value[COORD_BITS-1:0];
        else
            radius_sq_cfg = value[RADIUS_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_request(input t_op op, input t_coord x, input t_coord y);
        request_t rq;
        rq.op      = op;
        rq.x_coord = x;
        rq.y_coord = y;
        requests_pending.insert(requests_pending.size(), rq);
    endtask

    // Mostly inside the box, sometimes on its edges or anywhere in the field.
    function automatic t_coord rand_coord();
        case ($urandom_range(7))
            0:       return t_coord'($urandom());
            1:       return '0;
            2:       return box_len_cfg - 1'b1;
            default: return t_coord'($urandom_range(box_len_cfg - 1));
        endcase
    endfunction

    task automatic push_random(input int n);
        int  k;
        int  pick;
        t_op op;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                op = OP_LOAD;
            else if (pick < 75)
                op = OP_SAMPLE;
            else if (pick < 90)
                op = OP_READ;
            else
                op = OP_UNUSED;
            push_request(op, rand_coord(), rand_coord());
        end
    endtask

    initial begin
        logic [CFG_DATA_BITS-1:0] radius;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 32;
        recv_idle_pct = 56;

        // Directed: empty store, wrap-around across the box edge, points on and
        // beyond the box boundary, unused code, back-to-back reads.
        write_reg(CFG_BOX_LENGTH, 48'd1000);
        write_reg(CFG_RADIUS_SQ, 48'd90000);
        push_request(OP_READ, 24'd0, 24'd0);
        push_request(OP_UNUSED, 24'hFFFFFF, 24'hFFFFFF);
        push_request(OP_SAMPLE, 24'd0, 24'd0);
        push_request(OP_LOAD, 24'd0, 24'd0);
        push_request(OP_LOAD, 24'd999, 24'd999);
        push_request(OP_LOAD, 24'd500, 24'd500);
        push_request(OP_LOAD, 24'hFFFFFF, 24'hFFFFFF);
        push_request(OP_LOAD, 24'd1000, 24'd0);
        push_request(OP_SAMPLE, 24'd0, 24'd0);
        push_request(OP_SAMPLE, 24'd999, 24'd500);
        push_request(OP_SAMPLE, 24'hFFFFFF, 24'd0);
        push_request(OP_UNUSED, 24'd12345, 24'd54321);
        push_request(OP_READ, 24'd0, 24'd0);
        push_request(OP_READ, 24'hFFFFFF, 24'hFFFFFF);

        write_reg(CFG_BOX_LENGTH, 48'hFFFFFF);
        write_reg(CFG_RADIUS_SQ, 48'hFFFF_FFFF_FFFF);
        push_request(OP_SAMPLE, 24'd0, 24'd0);
        push_request(OP_SAMPLE, 24'd8388607, 24'hFFFFFF);
        push_request(OP_READ, 24'd0, 24'd0);

        write_reg(CFG_BOX_LENGTH, 48'd1);
        write_reg(CFG_RADIUS_SQ, 48'd0);
        push_request(OP_SAMPLE, 24'd0, 24'd0);
        push_request(OP_LOAD, 24'd1, 24'hFFFFFF);
        write_reg(CFG_RADIUS_SQ, 48'd1);
        push_request(OP_SAMPLE, 24'hFFFFFF, 24'd1);
        push_request(OP_READ, 24'd0, 24'd0);

        // Random, small box with a window about a third of its side.
        write_reg(CFG_BOX_LENGTH, 48'($urandom_range(5000, 500)));
        radius = 48'(box_len_cfg / 3);
        write_reg(CFG_RADIUS_SQ, radius * radius);
        push_random(40);

        // Hold the result side off while requests keep coming, so the block
        // backs up and stalls its request channel.
        wait_idle();
        stall_requests = stall_requests + 1;
        push_random(10);
        wait_idle();

        send_idle_pct = 56;
        recv_idle_pct = 32;
        write_reg(CFG_BOX_LENGTH, 48'(BOX_LENGTH_RESET));
        write_reg(CFG_RADIUS_SQ, {16'($urandom_range(16383)), $urandom()});
        push_random(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_BOX_LENGTH, 48'($urandom_range(16777215, 8000000)));
        radius = 48'(box_len_cfg / 4);
        write_reg(CFG_RADIUS_SQ, radius * radius);
        push_random(30);

        // Loads beyond the box in a small box, then samples across the wrap.
        write_reg(CFG_BOX_LENGTH, 48'd4096);
        write_reg(CFG_RADIUS_SQ, 48'd10000);
        push_request(OP_LOAD, 24'd1, 24'd2);
        push_request(OP_LOAD, 24'hFFFFFF, 24'd0);
        push_request(OP_SAMPLE, 24'd0, 24'd0);
        push_request(OP_UNUSED, 24'd7, 24'd7);
        push_request(OP_SAMPLE, 24'd2048, 24'd4095);
        push_request(OP_READ, 24'd0, 24'd0);
        wait_idle();
        repeat (16) @(posedge i_clk);

        $display("tb_top: %0d requests: %0d loads, %0d samples, %0d reads, %0d unused codes",
                 accepted, ops_seen[OP_LOAD], ops_seen[OP_SAMPLE], ops_seen[OP_READ],
                 ops_seen[OP_UNUSED]);
        $display("tb_top: %0d results checked, %0d loads dropped, %0d long result stalls",
                 results_checked, loads_dropped, stalls_served);
        if (errors == 0 && reports_due.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
